>>> rtl/fbbeq_pkg.sv
`timescale 1ns / 1ps

package fbbeq_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_REGS    = 5;
    localparam int BAND_SEL_W  = 3;
    localparam int DELAY_W     = 32;
    localparam int RECIP_SHIFT = 24;

    localparam logic [LEVEL_W-1:0] FLAT_LEVEL = 4'd5;
    localparam logic [LEVEL_W-1:0] TOP_LEVEL  = 4'd10;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [DELAY_W-1:0]  delay_t;

    typedef struct packed {
        sample_t b0;
        sample_t b1;
        sample_t b2;
        sample_t a1;
        sample_t a2;
    } coef_t;

    // datapath commands from the sequencer, pre and acc may share a cycle
    typedef struct packed {
        logic load;
        logic pre;
        logic fwd;
        logic fb;
        logic acc;
        logic div;
        logic out;
    } dp_cmd_t;

    localparam sample_t Q15_ONE = 16'sd32767;

    function automatic coef_t band_coef(input logic [BAND_SEL_W-1:0] b);
        coef_t c;
        case (b)
            3'd0: c = '{16'sd206,   16'sd0, -16'sd206,   -16'sd32710, 16'sd32355};
            3'd1: c = '{16'sd786,   16'sd0, -16'sd786,   -16'sd32426, 16'sd31197};
            3'd2: c = '{16'sd3002,  16'sd0, -16'sd3002,  -16'sd29900, 16'sd26763};
            3'd3: c = '{16'sd10560, 16'sd0, -16'sd10560, -16'sd15200, 16'sd11647};
            3'd4: c = '{16'sd18000, 16'sd0, -16'sd18000, 16'sd12000,  16'sd7000};
            default: c = '0;
        endcase
        return c;
    endfunction

    // cut levels scale the band input, flat and boost levels pass it
    function automatic sample_t pre_gain(input logic [LEVEL_W-1:0] lv);
        sample_t g;
        case (lv)
            4'd0:    g = 16'sd8192;
            4'd1:    g = 16'sd10362;
            4'd2:    g = 16'sd13045;
            4'd3:    g = 16'sd16423;
            4'd4:    g = 16'sd20675;
            default: g = Q15_ONE;
        endcase
        return g;
    endfunction

    function automatic sample_t post_gain(input logic [LEVEL_W-1:0] lv);
        sample_t g;
        case (lv)
            4'd6:    g = 16'sd20000;
            4'd7:    g = 16'sd23000;
            4'd8:    g = 16'sd26000;
            4'd9:    g = 16'sd29000;
            4'd10:   g = 16'sd32000;
            default: g = Q15_ONE;
        endcase
        return g;
    endfunction

    function automatic sample_t sat_q15(input logic signed [SAMPLE_W:0] v);
        sample_t r;
        if (v > 17'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -17'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    // q15 product, floor shift by 15, saturated
    function automatic sample_t q15_scale(input sample_t a, input sample_t b);
        logic signed [2*SAMPLE_W-1:0] p;
        p = a * b;
        return sat_q15(p[2*SAMPLE_W-1:SAMPLE_W-1]);
    endfunction

endpackage

>>> rtl/five_band_biquad_equalizer.sv
`timescale 1ns / 1ps

// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    s_tdata = sample_in, s_tlast = block_end_in
// m_*       out  m_tvalid/m_tready    m_tdata = sample_out, m_tlast = block_end_out
// cfg_*     in   cfg_valid/cfg_ready  cfg_index = band level register, cfg_data = level
//
// after the load, each band runs a pre-gain, a forward and a feedback
// step in turn, then come a final sum, the reciprocal multiply for the
// divide and the output write
// reset clears the filter delay words and sets every band level to flat
// a stalled output holds the sequencer at the output write; the next input
// word is taken once the result is in the output register

module five_band_biquad_equalizer
    import fbbeq_pkg::*;
#(
    parameter int BAND_COUNT = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // [15:0] sample_in
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,    // [15:0] sample_out
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data
);

    localparam int BandW = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

    dp_cmd_t          cmd;
    logic [BandW-1:0] band;
    logic             out_free;

    assign cfg_ready = 1'b1;

    fbbeq_ctrl #(
        .BAND_COUNT (BAND_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .cmd      (cmd),
        .band     (band)
    );

    fbbeq_datapath #(
        .BAND_COUNT (BAND_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .band      (band),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_free  (out_free),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

>>> rtl/fbbeq_ctrl.sv
`timescale 1ns / 1ps

module fbbeq_ctrl
    import fbbeq_pkg::*;
#(
    parameter int BAND_COUNT = 5,
    localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              out_free,
    output dp_cmd_t           cmd,
    output logic [BAND_W-1:0] band
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRE  = 3'd1;
    localparam logic [2:0] S_FWD  = 3'd2;
    localparam logic [2:0] S_FB   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [BAND_W-1:0] LastBand = BAND_W'(BAND_COUNT - 1);

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [BAND_W-1:0] band_reg;
    logic [BAND_W-1:0] band_next;

    assign s_tready = (state_reg == S_IDLE);
    assign band     = band_reg;

    always_comb
    begin
        state_next = state_reg;
        band_next  = band_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    band_next  = '0;
                    state_next = S_PRE;
                end
            end
            S_PRE:
            begin
                cmd.pre    = 1'b1;
                // previous band's scaled output lands in the sum here
                cmd.acc    = (band_reg != '0);
                state_next = S_FWD;
            end
            S_FWD:
            begin
                cmd.fwd    = 1'b1;
                state_next = S_FB;
            end
            S_FB:
            begin
                cmd.fb = 1'b1;
                if (band_reg == LastBand)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    band_next  = band_reg + 1'b1;
                    state_next = S_PRE;
                end
            end
            S_FIN:
            begin
                cmd.acc    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            band_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            band_reg  <= band_next;
        end
    end

    a_accept_starts_band0: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_PRE && band_reg == '0)
        else $error("accepted word did not start at the first band");

    a_band_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        band_reg <= LastBand)
        else $error("band counter beyond last band");

    a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && !out_free |=> state_reg == S_OUT)
        else $error("result left while output register still full");

endmodule

>>> rtl/fbbeq_datapath.sv
`timescale 1ns / 1ps

module fbbeq_datapath
    import fbbeq_pkg::*;
#(
    parameter int BAND_COUNT = 5,
    localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    input  logic [BAND_W-1:0]    band,
    input  logic [SAMPLE_W-1:0]  s_tdata,
    input  logic                 s_tlast,
    output logic [SAMPLE_W-1:0]  m_tdata,
    output logic                 m_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic                 out_free,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data
);

    localparam int Divisor = BAND_COUNT + 1;
    localparam int SumW    = SAMPLE_W + $clog2(BAND_COUNT + 1);
    localparam int RecipW  = RECIP_SHIFT + 1;
    localparam int ProdW   = SumW + RecipW;
    localparam logic [RecipW-1:0] Recip =
        RecipW'(((64'd1 << RECIP_SHIFT) + Divisor - 1) / Divisor);
    localparam logic signed [SumW+1:0] QMax = (SumW+2)'(32767);
    localparam logic signed [SumW+1:0] QMin = -(SumW+2)'(32768);

    sample_t                 x_reg;
    logic                    last_reg;
    sample_t                 xp_reg;
    sample_t                 y_reg;
    delay_t                  p1_reg;
    delay_t                  p2_reg;
    sample_t                 post_reg;
    logic signed [SumW-1:0]  sum_reg;
    logic [ProdW-1:0]        prod_reg;
    logic                    neg_reg;
    logic [SAMPLE_W-1:0]     out_data_reg;
    logic                    out_last_reg;
    logic                    out_valid_reg;
    delay_t                  w1_reg [BAND_COUNT];
    delay_t                  w2_reg [BAND_COUNT];
    logic [LEVEL_W-1:0]      level_reg [BAND_COUNT];

    coef_t                   coef;
    logic [LEVEL_W-1:0]      level;
    delay_t                  w1_rd;
    delay_t                  w2_rd;
    delay_t                  fwd_acc;
    delay_t                  w1_next;
    delay_t                  w2_next;
    logic [LEVEL_W-1:0]      cfg_level;
    logic [SumW-1:0]         sum_mag;
    logic [SumW:0]           quo;
    logic signed [SumW+1:0]  quo_s;
    sample_t                 out_next;

    assign coef  = band_coef(BAND_SEL_W'(band));
    assign level = level_reg[band];
    assign w1_rd = w1_reg[band];
    assign w2_rd = w2_reg[band];

    // biquad, direct form II transposed
    assign fwd_acc = coef.b0 * xp_reg + w1_rd;
    assign w1_next = p1_reg - coef.a1 * y_reg + w2_rd;
    assign w2_next = p2_reg - coef.a2 * y_reg;

    assign cfg_level = (cfg_data > TOP_LEVEL) ? TOP_LEVEL : cfg_data;

    // divide by band count plus one: magnitude times rounded-up reciprocal
    assign sum_mag = sum_reg[SumW-1] ? SumW'(-sum_reg) : SumW'(sum_reg);
    assign quo     = prod_reg[ProdW-1:RECIP_SHIFT];
    assign quo_s   = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    always_comb
    begin
        if (quo_s > QMax)
        begin
            out_next = 16'sh7fff;
        end
        else if (quo_s < QMin)
        begin
            out_next = 16'sh8000;
        end
        else
        begin
            out_next = quo_s[SAMPLE_W-1:0];
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= sample_t'(s_tdata);
            last_reg <= s_tlast;
        end
        if (cmd.pre)
        begin
            xp_reg <= q15_scale(x_reg, pre_gain(level));
        end
        if (cmd.fwd)
        begin
            y_reg  <= sat_q15(fwd_acc[DELAY_W-1:SAMPLE_W-1]);
            p1_reg <= coef.b1 * xp_reg;
            p2_reg <= coef.b2 * xp_reg;
        end
        if (cmd.fb)
        begin
            post_reg <= q15_scale(y_reg, post_gain(level));
        end
        if (cmd.load)
        begin
            sum_reg <= SumW'(sample_t'(s_tdata));
        end
        else if (cmd.acc)
        begin
            sum_reg <= sum_reg + SumW'(post_reg);
        end
        if (cmd.div)
        begin
            neg_reg  <= sum_reg[SumW-1];
            prod_reg <= ProdW'(sum_mag) * ProdW'(Recip);
        end
        if (cmd.out)
        begin
            out_data_reg <= out_next;
            out_last_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BAND_COUNT; b++)
            begin
                w1_reg[b]    <= '0;
                w2_reg[b]    <= '0;
                level_reg[b] <= FLAT_LEVEL;
            end
        end
        else
        begin
            if (cmd.fb)
            begin
                w1_reg[band] <= w1_next;
                w2_reg[band] <= w2_next;
            end
            for (int b = 0; b < BAND_COUNT; b++)
            begin
                if (cfg_valid && int'(cfg_index) == b && b < CFG_REGS)
                begin
                    level_reg[b] <= cfg_level;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out |-> !out_valid_reg || m_tready)
        else $error("output word overwritten before it was taken");

    a_sum_starts_dry: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> sum_reg == SumW'(x_reg))
        else $error("sum not seeded with the dry sample");

    a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.out))
        else $error("output valid rose without a result");

endmodule
